// File: hw/rtl/gcmap_pkg.sv
// ----------------------------------------------------------------------------
// gcmap_pkg
// Shared types, color stops and fixed-point constants for the colormap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gcmap_pkg;

    localparam int unsigned IN_W   = 16;  // intensity sample width
    localparam int unsigned FRAC_W = 16;  // fractional bits of stops and factor
    localparam int unsigned Q_W    = 17;  // Q1.16 value including 1.0
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned NUM_CH = 3;   // red, green, blue
    localparam int unsigned NUM_STOP = 5;

    // Segment thresholds on the raw sample (inclusive upper bounds)
    localparam logic [IN_W-1:0] SEG0_MAX = 16'd16383;
    localparam logic [IN_W-1:0] SEG1_MAX = 16'd36044;
    localparam logic [IN_W-1:0] SEG2_MAX = 16'd55704;

    // Offsets subtracted from 4*s to get the segment numerator
    localparam logic signed [19:0] SEG1_BASE = 20'sd65535;
    localparam logic signed [19:0] SEG2_BASE = 20'sd144177;
    localparam logic signed [19:0] SEG3_BASE = 20'sd222819;

    // Shared divisor for segments 1..3 and its rounding half
    localparam logic [Q_W-1:0] DIV_D    = 17'd78642;
    localparam logic [Q_W-1:0] DIV_HALF = 17'd39321;
    localparam logic [Q_W-1:0] ONE_Q16  = 17'd65536;

    // Reciprocal of DIV_D scaled by 2^48: quotient estimate is (m*K) >> 32
    localparam longint unsigned RECIP_FULL = (64'd1 << 48) / 64'd78642;
    localparam logic [31:0]     RECIP_K    = RECIP_FULL[31:0];

    // Sample at which segment 0 rounding adds one
    localparam logic [IN_W-1:0] SEG0_ROUND = 16'd8192;

    typedef enum logic [1:0] {
        SEG_0 = 2'd0,
        SEG_1 = 2'd1,
        SEG_2 = 2'd2,
        SEG_3 = 2'd3
    } seg_t;

    // Segment and interpolation factor handed from factor to blend stages
    typedef struct packed {
        seg_t             seg;
        logic [Q_W-1:0]   f;
    } fact_t;

    typedef logic [Q_W-1:0] stop_row_t [NUM_CH];

    // Color stops, unsigned Q1.16, rows are stops, columns red/green/blue
    localparam stop_row_t STOP_Q16 [NUM_STOP] = '{
        '{17'd1311,  17'd1966,  17'd5243 },
        '{17'd0,     17'd14418, 17'd39322},
        '{17'd0,     17'd49152, 17'd52429},
        '{17'd62259, 17'd55706, 17'd19661},
        '{17'd65536, 17'd65536, 17'd65536}
    };

endpackage

`default_nettype wire

// File: hw/rtl/gcmap_factor.sv
// ----------------------------------------------------------------------------
// gcmap_factor
// Four-stage pipeline: segment select, reciprocal multiply, remainder check.
// ----------------------------------------------------------------------------
`default_nettype none

module gcmap_factor (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [gcmap_pkg::IN_W-1:0]    in_intensity,
    output logic                               out_valid,
    output gcmap_pkg::fact_t                   out_fact
);

    localparam int unsigned QW = gcmap_pkg::Q_W;

    // Stage 1: segment, numerator, segment-0 factor
    logic                   v1_reg;
    gcmap_pkg::seg_t        seg1_reg, seg1_next;
    logic [QW-1:0]          m1_reg, m1_next;
    logic [QW-1:0]          f01_reg, f01_next;

    // Stage 2: quotient estimate
    logic                   v2_reg;
    gcmap_pkg::seg_t        seg2_reg;
    logic [QW-1:0]          m2_reg, f02_reg;
    logic [QW-1:0]          q2_reg, q2_next;
    logic [48:0]            prod2;

    // Stage 3: estimate times divisor
    logic                   v3_reg;
    gcmap_pkg::seg_t        seg3_reg;
    logic [QW-1:0]          m3_reg, f03_reg, q3_reg;
    logic [33:0]            qd3_reg, qd3_next;

    // Stage 4: correction and factor
    logic                   v4_reg;
    gcmap_pkg::fact_t       fact4_reg, fact4_next;

    logic [17:0]            s4;
    logic signed [19:0]     num;
    logic [34:0]            rem;
    logic [QW:0]            fq;

    always_comb begin
        s4        = {in_intensity, 2'b00};
        seg1_next = gcmap_pkg::SEG_0;
        num       = '0;
        m1_next   = '0;
        priority if (in_intensity <= gcmap_pkg::SEG0_MAX) begin
            seg1_next = gcmap_pkg::SEG_0;
        end else if (in_intensity <= gcmap_pkg::SEG1_MAX) begin
            seg1_next = gcmap_pkg::SEG_1;
            num       = $signed({2'b00, s4}) - gcmap_pkg::SEG1_BASE;
        end else if (in_intensity <= gcmap_pkg::SEG2_MAX) begin
            seg1_next = gcmap_pkg::SEG_2;
            num       = $signed({2'b00, s4}) - gcmap_pkg::SEG2_BASE;
        end else begin
            seg1_next = gcmap_pkg::SEG_3;
            num       = $signed({2'b00, s4}) - gcmap_pkg::SEG3_BASE;
        end
        // Segment 3 divides by half the shared divisor: double the numerator
        if (num < 0) begin
            m1_next = '0;
        end else if (seg1_next == gcmap_pkg::SEG_3) begin
            m1_next = {num[15:0], 1'b0};
        end else begin
            m1_next = num[QW-1:0];
        end
        // Segment 0: 4s*65536/65535 rounds to 4s, plus one from s = 8192 up
        f01_next = QW'(s4) + QW'(in_intensity >= gcmap_pkg::SEG0_ROUND);
    end

    assign prod2   = 49'(m1_reg) * 49'(gcmap_pkg::RECIP_K);
    assign q2_next = prod2[48:32];

    assign qd3_next = 34'(q2_reg) * 34'(gcmap_pkg::DIV_D);

    always_comb begin
        rem = 35'({m3_reg, 16'h0000}) + 35'(gcmap_pkg::DIV_HALF) - 35'(qd3_reg);
        fq  = (QW+1)'(q3_reg) + (QW+1)'(rem >= 35'(gcmap_pkg::DIV_D));
        fact4_next.seg = seg3_reg;
        if (seg3_reg == gcmap_pkg::SEG_0) begin
            fact4_next.f = f03_reg;
        end else if (fq > (QW+1)'(gcmap_pkg::ONE_Q16)) begin
            fact4_next.f = gcmap_pkg::ONE_Q16;
        end else begin
            fact4_next.f = fq[QW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            seg1_reg  <= seg1_next;
            m1_reg    <= m1_next;
            f01_reg   <= f01_next;
            seg2_reg  <= seg1_reg;
            m2_reg    <= m1_reg;
            f02_reg   <= f01_reg;
            q2_reg    <= q2_next;
            seg3_reg  <= seg2_reg;
            m3_reg    <= m2_reg;
            f03_reg   <= f02_reg;
            q3_reg    <= q2_reg;
            qd3_reg   <= qd3_next;
            fact4_reg <= fact4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_fact  = fact4_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gcmap_blend.sv
// ----------------------------------------------------------------------------
// gcmap_blend
// Two-stage per-channel lerp between color stops, clamp and byte rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module gcmap_blend (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire gcmap_pkg::fact_t              in_fact,
    output logic                               out_valid,
    output logic [gcmap_pkg::NUM_CH-1:0][gcmap_pkg::BYTE_W-1:0] out_rgb
);

    localparam int unsigned NCH = gcmap_pkg::NUM_CH;
    localparam int unsigned QW  = gcmap_pkg::Q_W;

    logic                       v1_reg;
    logic signed [35:0]         v_reg [NCH];
    logic signed [35:0]         v_next [NCH];
    logic                       v2_reg;
    logic [NCH-1:0][gcmap_pkg::BYTE_W-1:0] rgb_reg, rgb_next;

    logic [2:0]                 lo_idx, hi_idx;
    logic [QW-1:0]              a [NCH];
    logic [QW-1:0]              b [NCH];
    logic signed [17:0]         diff [NCH];
    logic [32:0]                vc [NCH];
    logic [40:0]                scaled [NCH];

    assign lo_idx = 3'(in_fact.seg);
    assign hi_idx = 3'(in_fact.seg) + 3'd1;

    // Stage 1: v = a*2^16 + (b - a)*f, 32 fractional bits
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            a[c]      = gcmap_pkg::STOP_Q16[lo_idx][c];
            b[c]      = gcmap_pkg::STOP_Q16[hi_idx][c];
            diff[c]   = $signed({1'b0, b[c]}) - $signed({1'b0, a[c]});
            v_next[c] = $signed({3'b000, a[c], 16'h0000})
                      + diff[c] * $signed({1'b0, in_fact.f});
        end
    end

    // Stage 2: clamp to 0..1, then byte = (v*255 + 2^31) >> 32
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (v_reg[c] < 0) begin
                vc[c] = '0;
            end else if (v_reg[c] > 36'sh1_0000_0000) begin
                vc[c] = 33'h1_0000_0000;
            end else begin
                vc[c] = v_reg[c][32:0];
            end
            scaled[c]  = {vc[c], 8'h00} - 41'(vc[c]) + 41'h0_8000_0000;
            rgb_next[c] = scaled[c][39:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg   <= v_next;
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_rgb   = rgb_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gradient_colormap_rgb_unit.sv
// ----------------------------------------------------------------------------
// gradient_colormap_rgb_unit
// Five-stop piecewise-linear colormap: 16-bit intensity word in, RGB word out.
// ----------------------------------------------------------------------------
// Path: an accepted word passes the factor stages, then the blend stages.
// Throughput: one word per cycle unless stalled; six stages advance together.
// A stalled output holds the pipeline; the input skid register takes one more
//   word, so s_tready depends only on registered state.
// Reset: synchronous, active low; clears all valid bits and the skid valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_colormap_rgb_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input word stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] intensity
    // output word stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    logic                               skid_valid_reg, skid_valid_next;
    logic [gcmap_pkg::IN_W-1:0]         skid_data_reg;
    logic                               en;
    logic                               pipe_valid;
    logic [gcmap_pkg::IN_W-1:0]         pipe_data;
    logic                               fact_valid;
    gcmap_pkg::fact_t                   fact;
    logic                               rgb_valid;
    logic [gcmap_pkg::NUM_CH-1:0][gcmap_pkg::BYTE_W-1:0] rgb;

    // Advance the whole pipeline unless a finished word is held at the output
    assign en = !rgb_valid || m_tready;

    // Take new words while the skid register is empty
    assign s_tready = !skid_valid_reg;

    // Feed from skid first; it holds the word that arrived during a stall
    assign pipe_valid = skid_valid_reg || s_tvalid;
    assign pipe_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            // drop the held word once the pipeline takes it
            if (en) begin
                skid_valid_next = 1'b0;
            end
        end else if (s_tvalid && !en) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg && s_tvalid && !en) begin
            skid_data_reg <= s_tdata;
        end
    end

    // Segment select and interpolation factor
    gcmap_factor u_factor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (pipe_valid),
        .in_intensity (pipe_data),
        .out_valid    (fact_valid),
        .out_fact     (fact)
    );

    // Per-channel blend; its last stage is the output register
    gcmap_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fact_valid),
        .in_fact   (fact),
        .out_valid (rgb_valid),
        .out_rgb   (rgb)
    );

    assign m_tvalid = rgb_valid;
    assign m_tdata  = rgb;

endmodule

`default_nettype wire
